>>> src/chte_pkg.sv
// shared constants, codes and types for the chained hash table engine
package chte_pkg;

    localparam int TABLE_BITS = 10;
    localparam int NODE_COUNT = 1024;
    localparam int NODE_BITS  = $clog2(NODE_COUNT);
    localparam int LINK_BITS  = $clog2(NODE_COUNT + 1);
    localparam int BUCKETS    = 1 << TABLE_BITS;
    localparam int KEY_W      = 64;
    localparam int IDX_W      = 10;

    localparam logic [LINK_BITS-1:0] LINK_NULL = LINK_BITS'(NODE_COUNT);

    localparam logic [63:0] MUL_M  = 64'hc6a4a7935bd1e995;
    localparam int          ROT_R  = 47;
    localparam logic [63:0] SEED   = 64'h8445d61a4e774912;
    localparam logic [63:0] H_INIT = SEED ^ (MUL_M << 3);

    typedef enum logic [1:0] {
        MODE_INSERT = 2'd0,
        MODE_LOOKUP = 2'd1,
        MODE_REMOVE = 2'd2,
        MODE_SPARE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

endpackage

>>> src/chte_if.sv
// handshake channels for request and response items
interface chte_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  mode;
    logic [63:0] page_key;
    modport source (output valid, output mode, output page_key, input ready);
    modport sink (input valid, input mode, input page_key, output ready);
endinterface

interface chte_rsp_if;
    logic       valid;
    logic       ready;
    logic [1:0] status;
    logic [9:0] node_index;
    modport source (output valid, output status, output node_index, input ready);
    modport sink (input valid, input status, input node_index, output ready);
endinterface

>>> src/chte_ram.sv
// generic single write port ram with registered read
module chte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/chte_hash.sv
// murmur single word hash, one 32x32 partial product per cycle
module chte_hash (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [chte_pkg::KEY_W-1:0]       i_key,
    output logic                             o_done,
    output logic [chte_pkg::TABLE_BITS-1:0]  o_bucket
);
    import chte_pkg::*;

    logic        r_busy, n_busy;
    logic [1:0]  r_op, n_op;
    logic [1:0]  r_ph, n_ph;
    logic [63:0] r_x, n_x;
    logic [63:0] r_acc, n_acc;
    logic        r_done, n_done;
    logic [TABLE_BITS-1:0] r_bucket, n_bucket;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod, sum, mixed;

    assign mul_a = (r_ph == 2'd1) ? r_x[63:32] : r_x[31:0];
    assign mul_b = (r_ph == 2'd2) ? MUL_M[63:32] : MUL_M[31:0];
    assign prod  = 64'(mul_a) * 64'(mul_b);
    assign sum   = r_acc + {prod[31:0], 32'd0};
    assign mixed = sum ^ (sum >> ROT_R);

    always_comb begin
        n_busy   = r_busy;
        n_op     = r_op;
        n_ph     = r_ph;
        n_x      = r_x;
        n_acc    = r_acc;
        n_done   = 1'b0;
        n_bucket = r_bucket;
        if (i_start) begin
            n_busy = 1'b1;
            n_op   = 2'd0;
            n_ph   = 2'd0;
            n_x    = i_key;
        end else if (r_busy) begin
            if (r_ph == 2'd0) begin
                n_acc = prod;
                n_ph  = 2'd1;
            end else if (r_ph == 2'd1) begin
                n_acc = sum;
                n_ph  = 2'd2;
            end else begin
                n_ph = 2'd0;
                n_op = r_op + 2'd1;
                case (r_op)
                    2'd0:    n_x = mixed;
                    2'd1:    n_x = H_INIT ^ sum;
                    2'd2:    n_x = mixed;
                    default: begin
                        n_busy   = 1'b0;
                        n_done   = 1'b1;
                        n_bucket = mixed[TABLE_BITS-1:0];
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_op   <= 2'd0;
            r_ph   <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_op   <= n_op;
            r_ph   <= n_ph;
        end
        r_x      <= n_x;
        r_acc    <= n_acc;
        r_bucket <= n_bucket;
    end

    assign o_done   = r_done;
    assign o_bucket = r_bucket;
endmodule

>>> src/chained_hash_table_engine.sv
// top level of the chained hash table engine
// usage:
// - request channel i_req carries mode (insert, lookup, remove) and a 64-bit page_key
// - response channel o_rsp carries status and node_index, one item per request
// - one request is in flight at a time; i_req.ready is high only while idle
// - after acceptance the request is hashed: four 64-bit multiplies, each as three
//   32x32 partial products on one shared multiplier; an insert then allocates and
//   links its node in the decide step, while lookup and remove walk the chain,
//   reading and comparing one node at a time, and a successful remove then
//   unlinks and frees the matched node before the response is offered
// - a new request is taken only once the previous result has moved to the output
//   register and the engine is back in idle
// - after reset the bucket head memory is swept to null, one entry per
//   cycle for all 1024 entries, with i_req.ready held low
// - the response sits in an output register; if the receiver stalls the
//   next request may still be accepted and hashed, and its result waits
//   until the register drains
// - nodes come from a bounded pool: freed nodes first, then fresh ones;
//   an insert into a full pool answers pool full with no state change
module chained_hash_table_engine (
    input  logic       i_clk,
    input  logic       i_rst_n,
    chte_req_if.sink   i_req,
    chte_rsp_if.source o_rsp
);
    import chte_pkg::*;

    typedef enum logic [9:0] {
        S_CLEAR  = 10'b0000000001,
        S_IDLE   = 10'b0000000010,
        S_HASH   = 10'b0000000100,
        S_DECIDE = 10'b0000001000,
        S_WALK   = 10'b0000010000,
        S_CMP    = 10'b0000100000,
        S_UNLINK = 10'b0001000000,
        S_FREE   = 10'b0010000000,
        S_RESP   = 10'b0100000000,
        S_SPARE  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    // request and walk context
    t_mode                 r_mode, n_mode;
    logic [KEY_W-1:0]      r_key, n_key;
    logic [LINK_BITS-1:0]  r_cur, n_cur;
    logic [LINK_BITS-1:0]  r_prev, n_prev;
    logic [LINK_BITS-1:0]  r_nxt, n_nxt;
    logic [LINK_BITS-1:0]  r_steps, n_steps;
    t_status               r_res_status, n_res_status;
    logic [IDX_W-1:0]      r_res_idx, n_res_idx;

    // pool bookkeeping
    logic [LINK_BITS-1:0]  r_free_head, n_free_head;
    logic [LINK_BITS-1:0]  r_fresh, n_fresh;
    logic [TABLE_BITS-1:0] r_clr_idx, n_clr_idx;

    // response register
    logic                  r_out_valid, n_out_valid;
    t_status               r_out_status, n_out_status;
    logic [IDX_W-1:0]      r_out_idx, n_out_idx;

    // hash unit
    logic                  hash_start, hash_done;
    logic [TABLE_BITS-1:0] bucket;

    // memory ports
    logic                  head_we;
    logic [TABLE_BITS-1:0] head_waddr;
    logic [LINK_BITS-1:0]  head_wdata, head_rdata;
    logic                  key_we;
    logic [NODE_BITS-1:0]  key_waddr, key_raddr;
    logic [KEY_W-1:0]      key_rdata;
    logic                  link_we;
    logic [NODE_BITS-1:0]  link_waddr, link_raddr;
    logic [LINK_BITS-1:0]  link_wdata, link_rdata;

    logic                  accept;
    logic                  out_free;
    logic [LINK_BITS-1:0]  alloc_node;
    logic                  alloc_ok;

    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_free    = !r_out_valid || o_rsp.ready;
    assign hash_start  = accept;

    chte_hash u_hash (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (hash_start),
        .i_key    (i_req.page_key),
        .o_done   (hash_done),
        .o_bucket (bucket)
    );

    chte_ram #(.WIDTH(LINK_BITS), .DEPTH(BUCKETS)) u_heads (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (bucket),
        .o_rdata (head_rdata)
    );

    chte_ram #(.WIDTH(KEY_W), .DEPTH(NODE_COUNT)) u_keys (
        .i_clk   (i_clk),
        .i_we    (key_we),
        .i_waddr (key_waddr),
        .i_wdata (r_key),
        .i_raddr (key_raddr),
        .o_rdata (key_rdata)
    );

    chte_ram #(.WIDTH(LINK_BITS), .DEPTH(NODE_COUNT)) u_links (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    // allocation: free list first, then the next fresh node
    always_comb begin
        alloc_ok   = 1'b1;
        alloc_node = LINK_NULL;
        if (r_free_head < LINK_NULL) begin
            alloc_node = r_free_head;
        end else if (r_fresh < LINK_NULL) begin
            alloc_node = r_fresh;
        end else begin
            alloc_ok = 1'b0;
        end
    end

    // key memory reads the walk cursor; link memory reads the free head while hashing
    assign key_raddr  = r_cur[NODE_BITS-1:0];
    assign link_raddr = (r_state == S_HASH) ? r_free_head[NODE_BITS-1:0]
                                            : r_cur[NODE_BITS-1:0];

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_cur        = r_cur;
        n_prev       = r_prev;
        n_nxt        = r_nxt;
        n_steps      = r_steps;
        n_res_status = r_res_status;
        n_res_idx    = r_res_idx;
        n_free_head  = r_free_head;
        n_fresh      = r_fresh;
        n_clr_idx    = r_clr_idx;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_idx    = r_out_idx;
        head_we      = 1'b0;
        head_waddr   = bucket;
        head_wdata   = LINK_NULL;
        key_we       = 1'b0;
        key_waddr    = alloc_node[NODE_BITS-1:0];
        link_we      = 1'b0;
        link_waddr   = alloc_node[NODE_BITS-1:0];
        link_wdata   = head_rdata;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                // sweep every bucket head to null
                head_we    = 1'b1;
                head_waddr = r_clr_idx;
                n_clr_idx  = r_clr_idx + 1'b1;
                if (r_clr_idx == TABLE_BITS'(BUCKETS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_mode  = t_mode'(i_req.mode);
                    n_key   = i_req.page_key;
                    n_state = S_HASH;
                end
            end
            S_HASH: begin
                if (hash_done) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (r_mode == MODE_INSERT) begin
                    n_state = S_RESP;
                    if (alloc_ok) begin
                        if (r_free_head < LINK_NULL) begin
                            n_free_head = link_rdata;
                        end else begin
                            n_fresh = r_fresh + 1'b1;
                        end
                        key_we       = 1'b1;
                        link_we      = 1'b1;
                        head_we      = 1'b1;
                        head_wdata   = alloc_node;
                        n_res_status = ST_OK;
                        n_res_idx    = IDX_W'(alloc_node);
                    end else begin
                        n_res_status = ST_FULL;
                        n_res_idx    = '0;
                    end
                end else begin
                    n_cur   = head_rdata;
                    n_prev  = LINK_NULL;
                    n_steps = '0;
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                if (r_cur < LINK_NULL && r_steps < LINK_NULL) begin
                    n_state = S_CMP;
                end else begin
                    n_res_status = ST_MISS;
                    n_res_idx    = '0;
                    n_state      = S_RESP;
                end
            end
            S_CMP: begin
                if (key_rdata == r_key) begin
                    n_nxt        = link_rdata;
                    n_res_status = ST_OK;
                    n_res_idx    = IDX_W'(r_cur);
                    n_state      = (r_mode == MODE_REMOVE) ? S_UNLINK : S_RESP;
                end else begin
                    n_prev  = r_cur;
                    n_cur   = link_rdata;
                    n_steps = r_steps + 1'b1;
                    n_state = S_WALK;
                end
            end
            S_UNLINK: begin
                // bypass the matched node from its predecessor or the bucket head
                if (r_prev < LINK_NULL) begin
                    link_we    = 1'b1;
                    link_waddr = r_prev[NODE_BITS-1:0];
                    link_wdata = r_nxt;
                end else begin
                    head_we    = 1'b1;
                    head_wdata = r_nxt;
                end
                n_state = S_FREE;
            end
            S_FREE: begin
                link_we     = 1'b1;
                link_waddr  = r_cur[NODE_BITS-1:0];
                link_wdata  = r_free_head;
                n_free_head = r_cur;
                n_state     = S_RESP;
            end
            S_RESP: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_idx    = r_res_idx;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_free_head <= LINK_NULL;
            r_fresh     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_out_valid <= n_out_valid;
        end
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_cur        <= n_cur;
        r_prev       <= n_prev;
        r_nxt        <= n_nxt;
        r_steps      <= n_steps;
        r_res_status <= n_res_status;
        r_res_idx    <= n_res_idx;
        r_out_status <= n_out_status;
        r_out_idx    <= n_out_idx;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.node_index = r_out_idx;
endmodule

>>> src/chte_checker.sv
// port level checks for the chained hash table engine, bound to the top level
module chte_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [1:0] i_status,
    input logic [9:0] i_node_index
);
    import chte_pkg::*;

    // a stalled response stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("response dropped while stalled");

    // only the three defined status codes appear
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_status == ST_OK || i_status == ST_MISS || i_status == ST_FULL))
        else $error("undefined status code");

    // failed items report node zero
    a_idx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_OK |-> i_node_index == '0)
        else $error("nonzero node index on failure");

    // one item in flight: no request taken right after another
    a_one_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("second request accepted while busy");
endmodule

bind chained_hash_table_engine chte_checker u_chte_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_req.valid),
    .i_in_ready   (i_req.ready),
    .i_out_valid  (o_rsp.valid),
    .i_out_ready  (o_rsp.ready),
    .i_status     (o_rsp.status),
    .i_node_index (o_rsp.node_index)
);
